### rtl/core/pbc_pkg.sv
`default_nettype none
package pbc_pkg;

	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_LC_N     = 8'h6E;
	localparam logic [7:0] CH_DIGIT_5  = 8'h35;
	localparam logic [7:0] CH_UC_C     = 8'h43;
	localparam logic [7:0] CH_ZERO     = 8'h00;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W       = $clog2(MAX_RESULTS);

	// One queued command: up to four result bytes produced by one input byte
	typedef struct packed {
		logic [CNT_W-1:0]                cnt;
		logic [MAX_RESULTS-1:0][7:0]     bytes;
		logic                            last;
		logic                            error;
	} cmd_t;

	function automatic logic is_alnum(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
		       (b >= 8'h30 && b <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
		       (b >= 8'h61 && b <= 8'h66);
	endfunction

	// valid only when is_hex(b)
	function automatic logic [3:0] hex_nib(input logic [7:0] b);
		return (b[6] == 1'b0) ? b[3:0] : 4'(b[3:0] + 4'd9);
	endfunction

	function automatic logic [7:0] hex_upper(input logic [3:0] v);
		return (v < 4'd10) ? 8'(8'h30 + {4'b0, v}) : 8'(8'h37 + {4'b0, v});
	endfunction

endpackage
`default_nettype wire

### rtl/core/pbc_in_if.sv
`default_nettype none
interface pbc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

### rtl/core/pbc_out_if.sv
`default_nettype none
interface pbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_error;

	modport source (output valid, output out_byte, output out_last, output out_error,
		input ready);
	modport sink   (input valid, input out_byte, input out_last, input out_error,
		output ready);
endinterface
`default_nettype wire

### rtl/core/pbc_cfg_if.sv
`default_nettype none
interface pbc_cfg_if;
	logic valid;
	logic ready;
	logic codec_mode;

	modport source (output valid, output codec_mode, input ready);
	modport sink   (input valid, input codec_mode, output ready);
endinterface
`default_nettype wire

### rtl/core/pbc_front.sv
`default_nettype none
module pbc_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pbc_cfg_if.sink       cfg,
	pbc_in_if.sink        msg,
	input  wire logic     q_full,
	output logic          push,
	output pbc_pkg::cmd_t push_cmd
);
	import pbc_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PCT,
		PH_HEX
	} phase_t;

	logic       mode_q;
	phase_t     phase_q, phase_d;
	logic [3:0] nib_q, nib_d;
	logic       bs_q, bs_d;
	logic       disc_q, disc_d;

	logic       accept;
	logic       have;
	logic       err;
	logic [7:0] d;
	logic [2:0] n;
	logic [7:0] b;
	logic       last;
	cmd_t       c;

	assign cfg.ready = 1'b1;
	assign msg.ready = !q_full;
	assign accept    = msg.valid && !q_full;
	assign b         = msg.in_byte;
	assign last      = msg.in_last;

	always_comb begin
		c       = '0;
		c.last  = last;
		phase_d = phase_q;
		nib_d   = nib_q;
		bs_d    = bs_q;
		disc_d  = disc_q;
		have    = 1'b0;
		err     = 1'b0;
		d       = b;
		n       = '0;
		if (mode_q == MODE_ENCODE) begin
			if (b == CH_NEWLINE) begin
				c.cnt      = CNT_W'(4);
				c.bytes[0] = CH_PERCENT;
				c.bytes[1] = CH_DIGIT_5;
				c.bytes[2] = CH_UC_C;
				c.bytes[3] = CH_LC_N;
			end else if (is_alnum(b)) begin
				c.cnt      = CNT_W'(1);
				c.bytes[0] = b;
			end else begin
				c.cnt      = CNT_W'(3);
				c.bytes[0] = CH_PERCENT;
				c.bytes[1] = hex_upper(b[7:4]);
				c.bytes[2] = hex_upper(b[3:0]);
			end
		end else if (disc_q) begin
			if (last) begin
				phase_d = PH_IDLE;
				nib_d   = '0;
				bs_d    = 1'b0;
				disc_d  = 1'b0;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (b == CH_PERCENT) phase_d = PH_PCT;
					else have = 1'b1;
				end
				PH_PCT: begin
					if (b == CH_PERCENT) begin
						have    = 1'b1;
						phase_d = PH_IDLE;
					end else if (is_hex(b)) begin
						nib_d   = hex_nib(b);
						phase_d = PH_HEX;
					end else begin
						err = 1'b1;
					end
				end
				PH_HEX: begin
					if (is_hex(b)) begin
						d       = {nib_q, hex_nib(b)};
						have    = 1'b1;
						phase_d = PH_IDLE;
						nib_d   = '0;
					end else begin
						err = 1'b1;
					end
				end
				default: err = 1'b1;
			endcase

			// backslash layer on the decoded byte
			if (have) begin
				if (bs_q) begin
					bs_d = 1'b0;
					if (d == CH_BSLASH) begin
						c.bytes[n[1:0]] = CH_BSLASH;
						n = n + 3'd1;
					end else if (d == CH_LC_N) begin
						c.bytes[n[1:0]] = CH_NEWLINE;
						n = n + 3'd1;
					end else begin
						c.bytes[n[1:0]] = CH_BSLASH;
						n = n + 3'd1;
						c.bytes[n[1:0]] = d;
						n = n + 3'd1;
					end
				end else if (d == CH_BSLASH) begin
					bs_d = 1'b1;
				end else begin
					c.bytes[n[1:0]] = d;
					n = n + 3'd1;
				end
			end

			// message ending inside an escape is an error too
			if (last && !err && phase_d != PH_IDLE) err = 1'b1;

			if (err) begin
				c       = '0;
				c.cnt   = CNT_W'(1);
				c.bytes = '0;
				c.last  = 1'b1;
				c.error = 1'b1;
				phase_d = PH_IDLE;
				nib_d   = '0;
				bs_d    = 1'b0;
				disc_d  = !last;
			end else begin
				if (last) begin
					if (bs_d) begin
						c.bytes[n[1:0]] = CH_BSLASH;
						n = n + 3'd1;
					end
					phase_d = PH_IDLE;
					nib_d   = '0;
					bs_d    = 1'b0;
					disc_d  = 1'b0;
				end
				c.cnt = CNT_W'(n);
			end
		end
	end

	assign push     = accept && (c.cnt != '0);
	assign push_cmd = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENCODE;
			phase_q <= PH_IDLE;
			nib_q   <= '0;
			bs_q    <= 1'b0;
			disc_q  <= 1'b0;
		end else if (cfg.valid) begin
			mode_q  <= cfg.codec_mode;
			phase_q <= PH_IDLE;
			nib_q   <= '0;
			bs_q    <= 1'b0;
			disc_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
			bs_q    <= bs_d;
			disc_q  <= disc_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/pbc_queue.sv
`default_nettype none
module pbc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pbc_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output pbc_pkg::cmd_t      head_cmd
);
	import pbc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop)      count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

### rtl/core/pbc_back.sv
`default_nettype none
module pbc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire pbc_pkg::cmd_t head_cmd,
	output logic               pop,
	pbc_out_if.source          result
);
	import pbc_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             error_q;
	logic             load;
	logic             final_byte;

	assign load       = !valid_q || result.ready;
	assign final_byte = (CNT_W'(idx_q) + CNT_W'(1)) == head_cmd.cnt;
	assign pop        = load && head_valid && final_byte;

	assign result.valid     = valid_q;
	assign result.out_byte  = byte_q;
	assign result.out_last  = last_q;
	assign result.out_error = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) idx_q <= final_byte ? '0 : idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			byte_q  <= head_cmd.bytes[idx_q];
			last_q  <= head_cmd.last && final_byte;
			error_q <= head_cmd.error;
		end
	end

endmodule
`default_nettype wire

### rtl/core/percent_backslash_text_codec.sv
// channel  dir  payload                        transfer when
// msg      in   in_byte[7:0], in_last          valid && ready
// result   out  out_byte[7:0], out_last, out_error  valid && ready
// cfg      in   codec_mode                     valid && ready (ready tied high)
//
// The front classifies a byte in the cycle it is taken and queues at most one
// command of one to four result bytes; the back drains one result byte per cycle
// unless the result channel stalls. The front takes new input bytes while earlier
// results still drain, as long as the command queue has room.
// Reset clears the mode to encode, all decode state and the queue.
// Input stalls only when the command queue is full; output stalls hold the
// result register while the front keeps filling the queue.
`default_nettype none
module percent_backslash_text_codec #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pbc_cfg_if.sink   cfg,
	pbc_in_if.sink    msg,
	pbc_out_if.source result
);
	import pbc_pkg::*;

	logic push, full, pop, head_valid;
	cmd_t push_cmd, head_cmd;

	pbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.msg      (msg),
		.q_full   (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pbc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	pbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.result     (result)
	);

endmodule
`default_nettype wire
